/* rtl/assert_macros.svh */
// Assertion macros shared by the rasterizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* rtl/brl_pkg.sv */
// Types and constants shared by the line rasterizer modules
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_X_OFFSET   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DRAW_COLOR = 2'd2;

  localparam logic [COLOR_W-1:0] DRAW_COLOR_RST = 24'hFFFFFF;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_type_e;

  // classification of one queued command
  typedef struct packed {
    logic is_load;
    logic has_len;
    logic steep;
    logic step_x_neg;
    logic step_y_neg;
  } brl_ctrl_t;

  localparam int unsigned CTRL_W = $bits(brl_ctrl_t);

endpackage

`default_nettype wire

/* rtl/brl_fifo.sv */
// Small register queue with registered entries and occupancy count
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module brl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(a_count_bound, count_q > CNT_W'(DEPTH), "queue count exceeds depth")
  `ASSERT_RST(a_push_fills, do_push |=> !empty_o, "queue empty after a transfer in")

endmodule

`default_nettype wire

/* rtl/brl_front.sv */
// Front end: classifies requests and derives line deltas on load
`timescale 1ns / 1ps
`default_nettype none

module brl_front
  import brl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                  req_type_i,
  input  wire logic [COORD_BITS-1:0] start_x_i,
  input  wire logic [COORD_BITS-1:0] start_y_i,
  input  wire logic [COORD_BITS-1:0] end_x_i,
  input  wire logic [COORD_BITS-1:0] end_y_i,
  output brl_ctrl_t                  ctrl_o,
  output logic      [COORD_BITS-1:0] major_end_o,
  output logic      [COORD_BITS-1:0] abs_dx_o,
  output logic      [COORD_BITS-1:0] abs_dy_o
);

  logic [COORD_BITS:0] dx, dy, neg_dx, neg_dy;

  assign dx     = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign dy     = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
  assign neg_dx = -dx;
  assign neg_dy = -dy;

  assign abs_dx_o = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign abs_dy_o = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

  always_comb begin
    ctrl_o.is_load    = (req_type_i == REQ_LOAD);
    ctrl_o.has_len    = (|abs_dx_o) || (|abs_dy_o);
    ctrl_o.steep      = (abs_dy_o > abs_dx_o);
    ctrl_o.step_x_neg = dx[COORD_BITS];
    ctrl_o.step_y_neg = dy[COORD_BITS];
  end

  assign major_end_o = ctrl_o.steep ? end_y_i : end_x_i;

endmodule

`default_nettype wire

/* rtl/brl_back.sv */
// Back end: holds the line state and steps one pixel per step command while a line is active
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module brl_back
  import brl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  input  brl_ctrl_t                  cmd_ctrl_i,
  input  wire logic [COORD_BITS-1:0] cmd_start_x_i,
  input  wire logic [COORD_BITS-1:0] cmd_start_y_i,
  input  wire logic [COORD_BITS-1:0] cmd_major_end_i,
  input  wire logic [COORD_BITS-1:0] cmd_abs_dx_i,
  input  wire logic [COORD_BITS-1:0] cmd_abs_dy_i,
  output logic                       cmd_pop_o,
  input  wire logic                  out_room_i,
  input  wire logic [COORD_BITS-1:0] x_offset_i,
  input  wire logic [COORD_BITS-1:0] y_offset_i,
  input  wire logic [COLOR_W-1:0]    draw_color_i,
  output logic                       out_push_o,
  output logic      [COORD_BITS:0]   pixel_x_o,
  output logic      [COORD_BITS:0]   pixel_y_o,
  output logic      [COLOR_W-1:0]    pixel_color_o,
  output logic                       last_pixel_o
);

  localparam int unsigned N = COORD_BITS;

  logic [N-1:0] cur_x_q, cur_x_d;
  logic [N-1:0] cur_y_q, cur_y_d;
  logic [N-1:0] major_end_q, major_end_d;
  logic [N-1:0] abs_dx_q, abs_dx_d;
  logic [N-1:0] abs_dy_q, abs_dy_d;
  logic         step_x_neg_q, step_x_neg_d;
  logic         step_y_neg_q, step_y_neg_d;
  logic         steep_q, steep_d;
  logic         active_q, active_d;
  logic [N:0]   err_q, err_d;

  logic [N-1:0] maj_delta, min_delta, cur_major;
  logic [N-1:0] x_inc, y_inc, next_x, next_y, next_major;
  logic [N+1:0] err_sum, err_dif;
  logic         minor_step, x_move, y_move, last;
  logic         take_load, do_step;

  assign take_load = cmd_valid_i && cmd_ctrl_i.is_load;
  assign do_step   = cmd_valid_i && !cmd_ctrl_i.is_load && active_q && out_room_i;
  assign cmd_pop_o = cmd_valid_i && (cmd_ctrl_i.is_load || !active_q || out_room_i);
  assign out_push_o = do_step;

  assign maj_delta = steep_q ? abs_dy_q : abs_dx_q;
  assign min_delta = steep_q ? abs_dx_q : abs_dy_q;
  assign cur_major = steep_q ? cur_y_q : cur_x_q;

  assign err_sum    = {1'b0, err_q} + {2'b00, min_delta};
  assign err_dif    = err_sum - {2'b00, maj_delta};
  assign minor_step = !err_dif[N+1];

  assign x_inc  = step_x_neg_q ? {N{1'b1}} : N'(1);
  assign y_inc  = step_y_neg_q ? {N{1'b1}} : N'(1);
  assign x_move = steep_q ? minor_step : 1'b1;
  assign y_move = steep_q ? 1'b1 : minor_step;
  assign next_x = x_move ? cur_x_q + x_inc : cur_x_q;
  assign next_y = y_move ? cur_y_q + y_inc : cur_y_q;
  assign next_major = steep_q ? next_y : next_x;
  assign last   = (next_major == major_end_q);

  assign pixel_x_o     = {cur_x_q[N-1], cur_x_q} + {x_offset_i[N-1], x_offset_i};
  assign pixel_y_o     = {cur_y_q[N-1], cur_y_q} + {y_offset_i[N-1], y_offset_i};
  assign pixel_color_o = draw_color_i;
  assign last_pixel_o  = last;

  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    major_end_d  = major_end_q;
    abs_dx_d     = abs_dx_q;
    abs_dy_d     = abs_dy_q;
    step_x_neg_d = step_x_neg_q;
    step_y_neg_d = step_y_neg_q;
    steep_d      = steep_q;
    active_d     = active_q;
    err_d        = err_q;
    if (take_load) begin
      cur_x_d      = cmd_start_x_i;
      cur_y_d      = cmd_start_y_i;
      major_end_d  = cmd_major_end_i;
      abs_dx_d     = cmd_abs_dx_i;
      abs_dy_d     = cmd_abs_dy_i;
      step_x_neg_d = cmd_ctrl_i.step_x_neg;
      step_y_neg_d = cmd_ctrl_i.step_y_neg;
      steep_d      = cmd_ctrl_i.steep;
      active_d     = cmd_ctrl_i.has_len;
      err_d        = '0;
    end else if (do_step) begin
      cur_x_d  = next_x;
      cur_y_d  = next_y;
      err_d    = minor_step ? err_dif[N:0] : err_sum[N:0];
      active_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      major_end_q  <= '0;
      abs_dx_q     <= '0;
      abs_dy_q     <= '0;
      step_x_neg_q <= 1'b0;
      step_y_neg_q <= 1'b0;
      steep_q      <= 1'b0;
      active_q     <= 1'b0;
      err_q        <= '0;
    end else begin
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      major_end_q  <= major_end_d;
      abs_dx_q     <= abs_dx_d;
      abs_dy_q     <= abs_dy_d;
      step_x_neg_q <= step_x_neg_d;
      step_y_neg_q <= step_y_neg_d;
      steep_q      <= steep_d;
      active_q     <= active_d;
      err_q        <= err_d;
    end
  end

  `ASSERT_RST(a_err_below_major, active_q |-> (err_q < {1'b0, maj_delta}), "error term not below major delta")
  `ASSERT_RST(a_not_at_end, active_q |-> (cur_major != major_end_q), "active line sits on its end point")

endmodule

`default_nettype wire

/* rtl/bresenham_line_rasterizer.sv */
// Path: a step passes through the registered command queue and the back end, its pixel through the result queue.
// Throughput: one command per cycle while the command queue is not full; the queues are each
// CMD_DEPTH / OUT_DEPTH entries deep, and the back end retires one command per cycle unless a step finds no room.
// Loads and idle steps retire without waiting for result room and give no pixel.
// Reset: rst_ni async active low clears queues and line state (idle), offsets to 0, color to white.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer
  import brl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned CMD_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH  = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // requests
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  req_type_i,
  input  wire logic [COORD_BITS-1:0] start_x_i,
  input  wire logic [COORD_BITS-1:0] start_y_i,
  input  wire logic [COORD_BITS-1:0] end_x_i,
  input  wire logic [COORD_BITS-1:0] end_y_i,
  // pixels
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [COORD_BITS:0]   pixel_x_o,
  output logic      [COORD_BITS:0]   pixel_y_o,
  output logic      [COLOR_W-1:0]    pixel_color_o,
  output logic                       last_pixel_o
);

  localparam int unsigned CMD_W = CTRL_W + 5 * COORD_BITS;
  localparam int unsigned OUT_W = 2 * (COORD_BITS + 1) + COLOR_W + 1;

  logic [COORD_BITS-1:0] x_offset_q, y_offset_q;
  logic [COLOR_W-1:0]    draw_color_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  brl_ctrl_t             fe_ctrl, cmd_ctrl;
  logic [COORD_BITS-1:0] fe_major_end, fe_abs_dx, fe_abs_dy;
  logic [COORD_BITS-1:0] cmd_start_x, cmd_start_y, cmd_major_end, cmd_abs_dx, cmd_abs_dy;
  logic [CMD_W-1:0]      cmd_wdata, cmd_rdata;
  logic                  cmd_empty, cmd_pop;

  logic [OUT_W-1:0]      out_wdata, out_rdata;
  logic                  out_full, out_push;
  logic [COORD_BITS:0]   be_pixel_x, be_pixel_y;
  logic [COLOR_W-1:0]    be_color;
  logic                  be_last;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_offset_q   <= '0;
      y_offset_q   <= '0;
      draw_color_q <= DRAW_COLOR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_X_OFFSET:   x_offset_q   <= pwdata[COORD_BITS-1:0];
        REG_Y_OFFSET:   y_offset_q   <= pwdata[COORD_BITS-1:0];
        REG_DRAW_COLOR: draw_color_q <= pwdata[COLOR_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_OFFSET:   prdata = APB_DATA_W'(x_offset_q);
      REG_Y_OFFSET:   prdata = APB_DATA_W'(y_offset_q);
      REG_DRAW_COLOR: prdata = APB_DATA_W'(draw_color_q);
      default:        prdata = '0;
    endcase
  end

  brl_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .req_type_i  (req_type_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .ctrl_o      (fe_ctrl),
    .major_end_o (fe_major_end),
    .abs_dx_o    (fe_abs_dx),
    .abs_dy_o    (fe_abs_dy)
  );

  assign cmd_wdata = {fe_ctrl, start_x_i, start_y_i, fe_major_end, fe_abs_dx, fe_abs_dy};

  brl_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_wdata),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign {cmd_ctrl, cmd_start_x, cmd_start_y, cmd_major_end, cmd_abs_dx, cmd_abs_dy} =
    cmd_rdata;

  brl_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (!cmd_empty),
    .cmd_ctrl_i      (cmd_ctrl),
    .cmd_start_x_i   (cmd_start_x),
    .cmd_start_y_i   (cmd_start_y),
    .cmd_major_end_i (cmd_major_end),
    .cmd_abs_dx_i    (cmd_abs_dx),
    .cmd_abs_dy_i    (cmd_abs_dy),
    .cmd_pop_o       (cmd_pop),
    .out_room_i      (!out_full),
    .x_offset_i      (x_offset_q),
    .y_offset_i      (y_offset_q),
    .draw_color_i    (draw_color_q),
    .out_push_o      (out_push),
    .pixel_x_o       (be_pixel_x),
    .pixel_y_o       (be_pixel_y),
    .pixel_color_o   (be_color),
    .last_pixel_o    (be_last)
  );

  assign out_wdata = {be_pixel_x, be_pixel_y, be_color, be_last};

  brl_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  assign {pixel_x_o, pixel_y_o, pixel_color_o, last_pixel_o} = out_rdata;

endmodule

`default_nettype wire

/* tb/brl_pixel_checker.sv */
// Pixel predictor and scoreboard for the line rasterizer testbench
`timescale 1ns / 1ps

module brl_pixel_checker
  import brl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  push,
  input  logic                  full,
  input  logic                  req_type_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [COORD_BITS:0]   pixel_x_o,
  input  logic [COORD_BITS:0]   pixel_y_o,
  input  logic [COLOR_W-1:0]    pixel_color_o,
  input  logic                  last_pixel_o,
  output int                    n_mismatch,
  output int                    n_pending
);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   pix_t;
  typedef logic        [COORD_BITS-1:0] delta_t;
  typedef logic        [COORD_BITS:0]   acc_t;

  typedef struct packed {
    pix_t               x;
    pix_t               y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  coord_t             x_off, y_off;
  logic [COLOR_W-1:0] color;

  coord_t cur_x, cur_y, major_end;
  delta_t abs_dx, abs_dy;
  logic   x_neg, y_neg, steep, active;
  acc_t   err;

  pixel_t pixels_due[$];
  int     errs;

  function automatic void latch_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int dx, dy;
    dx        = int'(ex) - int'(sx);
    dy        = int'(ey) - int'(sy);
    x_neg     = dx < 0;
    y_neg     = dy < 0;
    abs_dx    = delta_t'(dx < 0 ? -dx : dx);
    abs_dy    = delta_t'(dy < 0 ? -dy : dy);
    steep     = abs_dy > abs_dx;
    cur_x     = sx;
    cur_y     = sy;
    major_end = steep ? ey : ex;
    err       = '0;
    active    = (abs_dx != '0) || (abs_dy != '0);
  endfunction

  function automatic pixel_t advance_pixel();
    pixel_t p;
    int nx, ny;
    p.x   = pix_t'(int'(cur_x) + int'(x_off));
    p.y   = pix_t'(int'(cur_y) + int'(y_off));
    p.color = color;
    nx    = cur_x;
    ny    = cur_y;
    if (steep) begin
      ny += y_neg ? -1 : 1;
      err = err + abs_dx;
      if (err >= abs_dy) begin
        nx += x_neg ? -1 : 1;
        err = err - abs_dy;
      end
      p.last = (ny == int'(major_end));
    end else begin
      nx += x_neg ? -1 : 1;
      err = err + abs_dy;
      if (err >= abs_dx) begin
        ny += y_neg ? -1 : 1;
        err = err - abs_dx;
      end
      p.last = (nx == int'(major_end));
    end
    cur_x = coord_t'(nx);
    cur_y = coord_t'(ny);
    if (p.last) active = 1'b0;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t exp_px;
    logic   bad;
    if (!rst_ni) begin
      x_off  = '0;
      y_off  = '0;
      color  = DRAW_COLOR_RST;
      latch_line('0, '0, '0, '0);
      pixels_due.delete();
      errs   = 0;
      n_mismatch <= 0;
      n_pending  <= 0;
    end else begin
      if (pop && !empty) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                   $signed(pixel_x_o), $signed(pixel_y_o), pixel_color_o, last_pixel_o);
          errs++;
        end else begin
          exp_px = pixels_due.pop_front();
          bad    = 1'b0;
          if (exp_px.x !== pixel_x_o) begin
            $display("%0t: pixel_x expected %0d got %0d", $time, exp_px.x,
                     $signed(pixel_x_o));
            bad = 1'b1;
          end
          if (exp_px.y !== pixel_y_o) begin
            $display("%0t: pixel_y expected %0d got %0d", $time, exp_px.y,
                     $signed(pixel_y_o));
            bad = 1'b1;
          end
          if (exp_px.color !== pixel_color_o) begin
            $display("%0t: pixel_color expected %h got %h", $time, exp_px.color,
                     pixel_color_o);
            bad = 1'b1;
          end
          if (exp_px.last !== last_pixel_o) begin
            $display("%0t: last_pixel expected %b got %b", $time, exp_px.last,
                     last_pixel_o);
            bad = 1'b1;
          end
          if (bad) errs++;
        end
      end

      if (push && !full) begin
        if (req_type_i == REQ_LOAD) begin
          latch_line(start_x_i, start_y_i, end_x_i, end_y_i);
        end else if (active) begin
          pixels_due.push_back(advance_pixel());
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[REG_IDX_W+1:2])
          REG_X_OFFSET:   x_off = coord_t'(pwdata);
          REG_Y_OFFSET:   y_off = coord_t'(pwdata);
          REG_DRAW_COLOR: color = pwdata[COLOR_W-1:0];
          default: ;
        endcase
      end

      n_mismatch <= errs;
      n_pending  <= pixels_due.size();
    end
  end

endmodule

/* tb/tb_bresenham_line_rasterizer.sv */
// Testbench top: stimulus, handshake timing and verdict for the line rasterizer
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer;
  import brl_pkg::*;

  localparam int unsigned COORD_BITS  = 12;
  localparam int          ITEMS       = 1700;
  localparam int          PHASE_ITEMS = 200;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN       = 10;
  localparam int          WD_LIMIT    = 3000;
  localparam int          MAX_STEPS   = 250;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {POP_ALWAYS, POP_RANDOM, POP_SPARSE, POP_STALL} pop_mode_e;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  push    = 1'b0;
  logic                  full;
  req_type_e             req_type = REQ_LOAD;
  logic [COORD_BITS-1:0] start_x = '0;
  logic [COORD_BITS-1:0] start_y = '0;
  logic [COORD_BITS-1:0] end_x   = '0;
  logic [COORD_BITS-1:0] end_y   = '0;
  logic                  empty;
  logic                  pop     = 1'b0;
  logic [COORD_BITS:0]   pixel_x, pixel_y;
  logic [COLOR_W-1:0]    pixel_color;
  logic                  last_pixel;

  int n_mismatch, n_pending;
  int n_sent      = 0;
  int burst_left  = 0;
  int hold_cnt    = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  bresenham_line_rasterizer #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type),
    .start_x_i     (start_x),
    .start_y_i     (start_y),
    .end_x_i       (end_x),
    .end_y_i       (end_y),
    .empty         (empty),
    .pop           (pop),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (last_pixel)
  );

  brl_pixel_checker #(.COORD_BITS(COORD_BITS)) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type),
    .start_x_i     (start_x),
    .start_y_i     (start_y),
    .end_x_i       (end_x),
    .end_y_i       (end_y),
    .empty         (empty),
    .pop           (pop),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (last_pixel),
    .n_mismatch    (n_mismatch),
    .n_pending     (n_pending)
  );

  // nothing transferred for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stall pattern; a hold request parks pop low for a long stretch
  initial begin : rx_stall
    pop_mode_e mode;
    int left, tick, holds_done;
    mode = POP_ALWAYS;
    left = 0;
    tick = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt != holds_done) begin
        holds_done = hold_cnt;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = pop_mode_e'($urandom_range(0, 3));
          left = $urandom_range(4, 50);
        end
        left--;
        tick++;
        case (mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_RANDOM: pop <= 1'($urandom_range(0, 1));
          POP_SPARSE: pop <= (tick % 3 == 0);
          default:    pop <= 1'b0;
        endcase
      end
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_item(req_type_e rt, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                           logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
    int gap;
    push     <= 1'b1;
    req_type <= rt;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    do @(posedge clk_i); while (full);
    n_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic run_steps(int n);
    repeat (n) push_item(REQ_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  // wait for all pixels, then let trailing loads and idle steps retire
  task automatic drain_block();
    push <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic int clamp_coord(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  task automatic run_line();
    int roll, span, sx, sy, ex, ey, adx, ady, len, n;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      push_item(req_type_e'($urandom_range(0, 1)), COORD_BITS'($urandom),
                COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom));
      return;
    end
    span = (roll < 18) ? 4095 : ((roll < 30) ? 200 : 20);
    sx   = $urandom_range(0, 4095) - 2048;
    sy   = $urandom_range(0, 4095) - 2048;
    ex   = clamp_coord(sx + $urandom_range(0, 2 * span) - span);
    ey   = clamp_coord(sy + $urandom_range(0, 2 * span) - span);
    adx  = (ex > sx) ? ex - sx : sx - ex;
    ady  = (ey > sy) ? ey - sy : sy - ey;
    len  = (adx > ady) ? adx : ady;
    push_item(REQ_LOAD, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex), COORD_BITS'(ey));
    roll = $urandom_range(0, 99);
    if (roll < 75) n = len;
    else if (roll < 88) n = len + $urandom_range(1, 3);
    else n = $urandom_range(0, len);
    if (n > MAX_STEPS) n = $urandom_range(0, MAX_STEPS);
    run_steps(n);
  endtask

  initial begin : stimulus
    int phase, target;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // step with no line loaded, then a zero-length line
    push_item(REQ_STEP, '1, '1, '1, '1);
    push_item(REQ_LOAD, 12'd5, 12'd5, 12'd5, 12'd5);
    run_steps(1);
    // corner-to-corner diagonals, each cut short by a fresh load
    push_item(REQ_LOAD, 12'h800, 12'h800, 12'h7FF, 12'h7FF);
    run_steps(3);
    push_item(REQ_LOAD, 12'h7FF, 12'h7FF, 12'h800, 12'h800);
    run_steps(2);
    push_item(REQ_LOAD, 12'h7FF, 12'h800, 12'h800, 12'h7FF);
    run_steps(1);
    // short diagonal run to its end, one step past it
    push_item(REQ_LOAD, 12'd0, 12'd0, 12'd3, -12'sd3);
    run_steps(4);
    // steep, y decreasing
    push_item(REQ_LOAD, 12'h800, 12'h7FF, 12'h801, 12'h7FA);
    run_steps(6);
    // shallow, x decreasing
    push_item(REQ_LOAD, 12'd10, -12'sd7, 12'd2, -12'sd4);
    run_steps(8);

    phase = 0;
    while (n_sent < ITEMS) begin
      drain_block();
      case (phase)
        0: begin
          write_reg(REG_X_OFFSET, 2047);
          write_reg(REG_Y_OFFSET, -2048);
          write_reg(REG_DRAW_COLOR, 0);
        end
        1: begin
          write_reg(REG_X_OFFSET, -2048);
          write_reg(REG_Y_OFFSET, 2047);
          write_reg(REG_DRAW_COLOR, 32'hFFFFFF);
          write_reg(REG_UNUSED, $urandom);
        end
        default: begin
          write_reg(REG_X_OFFSET, $urandom_range(0, 4095) - 2048);
          write_reg(REG_Y_OFFSET, $urandom_range(0, 4095) - 2048);
          write_reg(REG_DRAW_COLOR, $urandom_range(0, 32'hFFFFFF));
        end
      endcase
      if (phase == 1) begin
        // receiver holds off while a long line keeps the input busy
        hold_cnt <= hold_cnt + 1;
        push_item(REQ_LOAD, 12'd0, 12'd0, 12'd60, 12'd25);
        run_steps(60);
      end
      target = n_sent + PHASE_ITEMS;
      while (n_sent < target && n_sent < ITEMS) run_line();
      phase++;
    end
    drain_block();

    if (n_mismatch == 0 && n_pending == 0 && empty) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
